/* design/assert_macros.svh */
// assertion helper macros for the deframer
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define PPD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define PPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/ppd_pkg.sv */
// shared types and constants for the printer packet deframer
// no dependencies
`default_nettype none

package ppd_pkg;

  localparam int unsigned POS_W = 17;

  typedef logic [POS_W-1:0] pos_t;

  localparam logic [7:0] SYNC_FIRST  = 8'h88;
  localparam logic [7:0] SYNC_SECOND = 8'h33;
  localparam logic [7:0] BUF_MIN     = 8'd4;
  localparam logic [7:0] BUF_RESET   = 8'd255;
  localparam logic [15:0] LEN_LO_MASK = 16'h00FF;
  localparam logic [15:0] LEN_HI_MASK = 16'hFF00;

  // byte positions within the header
  localparam pos_t POS_HUNT1  = pos_t'(0);
  localparam pos_t POS_HUNT2  = pos_t'(1);
  localparam pos_t POS_CMD    = pos_t'(2);
  localparam pos_t POS_COMP   = pos_t'(3);
  localparam pos_t POS_LEN_LO = pos_t'(4);
  localparam pos_t POS_LEN_HI = pos_t'(5);
  localparam pos_t POS_DATA   = pos_t'(6);

  typedef enum logic [1:0] {
    EV_NONE       = 2'd0,
    EV_GOT_PACKET = 2'd1,
    EV_CHUNK_FULL = 2'd2,
    EV_STREAM_END = 2'd3
  } event_t;

  typedef struct packed {
    event_t      event_res;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_slot;
    logic [7:0]  buffer_fill;
    logic [7:0]  command_code;
    logic [7:0]  compression_flag;
    logic [15:0] payload_length;
    logic [7:0]  device_id;
    logic [7:0]  status_byte;
  } result_t;

endpackage

`default_nettype wire

/* design/ppd_core.sv */
// deframer state and per-word result logic
// depends on ppd_pkg
`default_nettype none

module ppd_core
  import ppd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step_en,
  input  wire logic [7:0] in_byte,
  input  wire logic [7:0] buffer_max,
  output result_t         result
);

  pos_t        pos_r, pos_nxt;
  logic [7:0]  command_r, command_nxt;
  logic [7:0]  compression_r, compression_nxt;
  logic [15:0] length_r, length_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [7:0]  status_r, status_nxt;
  logic [7:0]  fill_r, fill_nxt;
  logic [7:0]  wrap_r, wrap_nxt;

  pos_t        data_end;
  logic [8:0]  usage;
  event_t      ev;
  logic        pv;
  logic [7:0]  pb;
  logic [7:0]  ps;

  always_comb begin
    pos_nxt         = pos_r;
    command_nxt     = command_r;
    compression_nxt = compression_r;
    length_nxt      = length_r;
    id_nxt          = id_r;
    status_nxt      = status_r;
    fill_nxt        = fill_r;
    wrap_nxt        = wrap_r;
    ev              = EV_NONE;
    pv              = 1'b0;
    pb              = 8'd0;
    ps              = 8'd0;
    data_end        = POS_DATA + pos_t'(length_r);
    usage           = {1'b0, wrap_r} + 9'd1;

    if (buffer_max >= BUF_MIN) begin
      if (pos_r <= POS_LEN_HI) begin
        // new packet: clear everything captured from the last one
        if (pos_r == POS_HUNT2) begin
          command_nxt     = 8'd0;
          compression_nxt = 8'd0;
          length_nxt      = 16'd0;
          id_nxt          = 8'd0;
          status_nxt      = 8'd0;
          fill_nxt        = 8'd0;
          wrap_nxt        = 8'd0;
        end
        case (pos_r)
          POS_HUNT1: begin
            pos_nxt = (in_byte == SYNC_FIRST) ? POS_HUNT2 : POS_HUNT1;
          end
          POS_HUNT2: begin
            pos_nxt = (in_byte == SYNC_SECOND) ? POS_CMD : POS_HUNT1;
          end
          POS_CMD: begin
            command_nxt = in_byte;
            pos_nxt     = POS_COMP;
          end
          POS_COMP: begin
            compression_nxt = in_byte;
            pos_nxt         = POS_LEN_LO;
          end
          POS_LEN_LO: begin
            length_nxt = {8'd0, in_byte} & LEN_LO_MASK;
            pos_nxt    = POS_LEN_HI;
          end
          POS_LEN_HI: begin
            length_nxt = length_r | ({in_byte, 8'd0} & LEN_HI_MASK);
            pos_nxt    = POS_DATA;
            if ({8'd0, buffer_max} <= length_nxt) begin
              ev = EV_GOT_PACKET;
            end
          end
          default: begin
            pos_nxt = pos_r;
          end
        endcase
      end else begin
        if (pos_r < data_end) begin
          pv       = 1'b1;
          pb       = in_byte;
          ps       = wrap_r;
          fill_nxt = usage[7:0];
          if ({7'd0, usage} == length_r) begin
            ev = EV_NONE;
          end else if (usage == {1'b0, buffer_max}) begin
            ev = EV_CHUNK_FULL;
          end
          wrap_nxt = (usage >= {1'b0, buffer_max}) ? 8'd0 : usage[7:0];
        end else if (pos_r == data_end) begin
          fill_nxt = wrap_r;
        end

        if (pos_r == data_end + pos_t'(2)) begin
          id_nxt  = in_byte;
          pos_nxt = pos_r + pos_t'(1);
        end else if (pos_r == data_end + pos_t'(3)) begin
          status_nxt = in_byte;
          pos_nxt    = POS_HUNT1;
          ev = ({8'd0, buffer_max} > length_r) ? EV_GOT_PACKET : EV_STREAM_END;
        end else begin
          pos_nxt = pos_r + pos_t'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r         <= POS_HUNT1;
      command_r     <= 8'd0;
      compression_r <= 8'd0;
      length_r      <= 16'd0;
      id_r          <= 8'd0;
      status_r      <= 8'd0;
      fill_r        <= 8'd0;
      wrap_r        <= 8'd0;
    end else if (step_en) begin
      pos_r         <= pos_nxt;
      command_r     <= command_nxt;
      compression_r <= compression_nxt;
      length_r      <= length_nxt;
      id_r          <= id_nxt;
      status_r      <= status_nxt;
      fill_r        <= fill_nxt;
      wrap_r        <= wrap_nxt;
    end
  end

  always_comb begin
    result.event_res        = ev;
    result.payload_valid    = pv;
    result.payload_byte     = pb;
    result.payload_slot     = ps;
    result.buffer_fill      = fill_nxt;
    result.command_code     = command_nxt;
    result.compression_flag = compression_nxt;
    result.payload_length   = length_nxt;
    result.device_id        = id_nxt;
    result.status_byte      = status_nxt;
  end

endmodule

`default_nettype wire

/* design/ppd_outbuf.sv */
// result register with one skid entry behind it
// depends on ppd_pkg
`default_nettype none

module ppd_outbuf
  import ppd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    load,
  input  wire result_t load_data,
  output logic         full,
  output logic         out_valid,
  input  wire logic    out_stall,
  output result_t      out_data
);

  logic    main_valid_r;
  logic    skid_valid_r;
  result_t main_r;
  result_t skid_r;
  logic    take;

  assign take      = main_valid_r & ~out_stall;
  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (take) begin
        skid_valid_r <= 1'b0;
      end
    end else if (load) begin
      if (!main_valid_r || take) begin
        main_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (take) begin
      main_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (take) begin
        main_r <= skid_r;
      end
    end else if (load) begin
      if (!main_valid_r || take) begin
        main_r <= load_data;
      end else begin
        skid_r <= load_data;
      end
    end
  end

endmodule

`default_nettype wire

/* design/printer_packet_deframer.sv */
// Packet deframer for a serial byte link: hunts for the 0x88 0x33 sync pair,
// captures command, compression flag and a little-endian 16-bit length,
// then tags each payload word with a chunk slot that wraps at buffer_max,
// skips the two checksum words and latches the device id and status words.
// One input word is taken per clock while in_stall is low and gives exactly
// one result word, registered in the result register or, if that is held, in
// the skid entry, which keeps the input side open when the output stalls; so
// throughput is one word per clock while out_stall stays low. The buffer size
// register may be written at any time the block holds no undelivered result.
`default_nettype none

module printer_packet_deframer
  import ppd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_event_res,
  output logic             out_payload_valid,
  output logic [7:0]       out_payload_byte,
  output logic [7:0]       out_payload_slot,
  output logic [7:0]       out_buffer_fill,
  output logic [7:0]       out_command_code,
  output logic [7:0]       out_compression_flag,
  output logic [15:0]      out_payload_length,
  output logic [7:0]       out_device_id,
  output logic [7:0]       out_status_byte,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_buffer_max
);

  `include "assert_macros.svh"

  logic [7:0] buffer_max_r;
  logic       in_accept;
  logic       buf_full;
  result_t    step_res;
  result_t    out_res;

  assign cfg_ready = 1'b1;
  assign in_stall  = buf_full;
  assign in_accept = in_valid & ~buf_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buffer_max_r <= BUF_RESET;
    end else if (cfg_valid && cfg_ready) begin
      buffer_max_r <= cfg_buffer_max;
    end
  end

  ppd_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (in_accept),
    .in_byte    (in_byte),
    .buffer_max (buffer_max_r),
    .result     (step_res)
  );

  ppd_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_accept),
    .load_data (step_res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_res)
  );

  assign out_event_res        = out_res.event_res;
  assign out_payload_valid    = out_res.payload_valid;
  assign out_payload_byte     = out_res.payload_byte;
  assign out_payload_slot     = out_res.payload_slot;
  assign out_buffer_fill      = out_res.buffer_fill;
  assign out_command_code     = out_res.command_code;
  assign out_compression_flag = out_res.compression_flag;
  assign out_payload_length   = out_res.payload_length;
  assign out_device_id        = out_res.device_id;
  assign out_status_byte      = out_res.status_byte;

  // skid entry only fills behind a held result
  `PPD_ASSERT_NOW(a_skid_behind_main, clk, rst_n, in_stall, out_valid,
                  "skid entry full with no result on the output")
  // payload words only carry the chunk-full event or none
  `PPD_ASSERT_NOW(a_payload_event, clk, rst_n, out_valid && out_payload_valid,
                  (out_event_res == EV_NONE || out_event_res == EV_CHUNK_FULL),
                  "payload word carries a packet event")
  // non-payload words carry zero byte and slot
  `PPD_ASSERT_NOW(a_idle_payload_zero, clk, rst_n, out_valid && !out_payload_valid,
                  (out_payload_byte == 8'd0 && out_payload_slot == 8'd0),
                  "payload fields set on a non-payload word")
  // a held result with full skid frees the input once taken
  `PPD_ASSERT_NEXT(a_skid_drains, clk, rst_n, in_stall && !out_stall, !in_stall,
                   "skid entry not drained after result was taken")

endmodule

`default_nettype wire
